/* src/hesc_pkg.sv */
package hesc_pkg;

  // Default number of classified requests held between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Widths of the byte index within one expansion
  localparam int IDX_W = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // What the back end has to emit for one request
  typedef enum logic [2:0] {
    KIND_BYTE,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS,
    KIND_LT,
    KIND_GT,
    KIND_PERCNT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } entry_t;

  // Entity strings, first character in the top byte, padded with zeros
  localparam logic [63:0] STR_AMP    = {"&amp;", 24'h0};
  localparam logic [63:0] STR_QUOT   = {"&quot;", 16'h0};
  localparam logic [63:0] STR_APOS   = {"&apos;", 16'h0};
  localparam logic [63:0] STR_LT     = {"&lt;", 32'h0};
  localparam logic [63:0] STR_GT     = {"&gt;", 32'h0};
  localparam logic [63:0] STR_PERCNT = "&percnt;";

  // Index of the final output byte for a kind
  function automatic logic [IDX_W-1:0] last_idx(kind_t kind);
    logic [IDX_W-1:0] r;
    case (kind)
      KIND_BYTE:   r = 3'd0;
      KIND_AMP:    r = 3'd4;
      KIND_QUOT:   r = 3'd5;
      KIND_APOS:   r = 3'd5;
      KIND_LT:     r = 3'd3;
      KIND_GT:     r = 3'd3;
      KIND_PERCNT: r = 3'd7;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  // Output byte at position idx of the expansion of one request
  function automatic logic [7:0] out_char(entry_t e, logic [IDX_W-1:0] idx);
    logic [63:0] s;
    logic [7:0]  r;
    case (e.kind)
      KIND_AMP:    s = STR_AMP;
      KIND_QUOT:   s = STR_QUOT;
      KIND_APOS:   s = STR_APOS;
      KIND_LT:     s = STR_LT;
      KIND_GT:     s = STR_GT;
      KIND_PERCNT: s = STR_PERCNT;
      default:     s = {e.data, 56'h0};
    endcase
    s = s << {idx, 3'b000};
    r = s[63:56];
    return r;
  endfunction

endpackage

/* src/html_escape_utf8_passthrough.sv */
// HTML escaper with UTF-8 passthrough. The front end accepts one input byte
// per cycle while the queue is not full, tracks the raw UTF-8 run and
// classifies the byte; dropped control bytes never reach the back end.
// Classified requests wait in a queue of QUEUE_DEPTH entries, and the back
// end emits one output byte per cycle from its output register while
// res_stall is low: a plain byte is one output byte, an entity as many output
// bytes as it has characters (4 to 8). Sustained throughput is therefore one
// input byte per cycle for plain text and one output byte per cycle under
// entity expansion, with the input stalled once the queue is full. A request
// is written to the queue; its bytes then load into the output register.
module html_escape_utf8_passthrough #(
  parameter int QUEUE_DEPTH = hesc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  hesc_pkg::in_t  item,
  output logic           res_valid,
  input  logic           res_stall,
  output hesc_pkg::out_t res
);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  hesc_pkg::entry_t push_entry;
  hesc_pkg::entry_t head;

  hesc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .full       (full),
    .item_stall (item_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  hesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  hesc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

/* src/hesc_front.sv */
module hesc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  hesc_pkg::in_t     item,
  input  logic              full,
  output logic              item_stall,
  output logic              push,
  output hesc_pkg::entry_t  push_entry
);

  logic [1:0] raw_bytes_left;
  logic [1:0] raw_bytes_left_next;
  logic [1:0] left_now;
  logic       drop;
  logic       accept;
  logic [7:0] c;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign c          = item.in_byte;

  // Classify the byte and work out the run count it leaves
  always_comb begin
    left_now            = item.string_start ? 2'd0 : raw_bytes_left;
    raw_bytes_left_next = 2'd0;
    drop                = 1'b0;
    push_entry.data     = c;
    push_entry.kind     = hesc_pkg::KIND_BYTE;
    if (left_now != 2'd0) begin
      raw_bytes_left_next = left_now - 2'd1;
    end else if (c[7]) begin
      if (c[7:5] == 3'b110) begin
        raw_bytes_left_next = 2'd1;
      end else if (c[7:4] == 4'b1110) begin
        raw_bytes_left_next = 2'd2;
      end else if (c[7:3] == 5'b11110) begin
        raw_bytes_left_next = 2'd3;
      end
    end else begin
      case (c)
        8'h26:   push_entry.kind = hesc_pkg::KIND_AMP;
        8'h22:   push_entry.kind = hesc_pkg::KIND_QUOT;
        8'h27:   push_entry.kind = hesc_pkg::KIND_APOS;
        8'h3C:   push_entry.kind = hesc_pkg::KIND_LT;
        8'h3E:   push_entry.kind = hesc_pkg::KIND_GT;
        8'h25:   push_entry.kind = hesc_pkg::KIND_PERCNT;
        default: drop = (c < 8'h20) || (c == 8'h7F);
      endcase
    end
  end

  assign push = accept && !drop;

  // Advance the run count on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_bytes_left <= 2'd0;
    end else if (accept) begin
      raw_bytes_left <= raw_bytes_left_next;
    end
  end

endmodule

/* src/hesc_queue.sv */
module hesc_queue #(
  parameter int DEPTH = hesc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hesc_pkg::entry_t  push_entry,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output hesc_pkg::entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hesc_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and hold the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* src/hesc_back.sv */
module hesc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  hesc_pkg::entry_t  head,
  output logic              pop,
  input  logic              res_stall,
  output logic              res_valid,
  output hesc_pkg::out_t    res
);

  logic [hesc_pkg::IDX_W-1:0] idx;
  logic                       load;
  logic                       last;

  // Emit the next byte whenever the output register is free
  assign load = (!res_valid || !res_stall) && !empty;
  assign last = (idx == hesc_pkg::last_idx(head.kind));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (!res_valid || !res_stall) begin
        res_valid <= !empty;
      end
      if (load) begin
        idx <= last ? '0 : idx + hesc_pkg::IDX_W'(1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      res.out_byte    <= hesc_pkg::out_char(head, idx);
      res.last_of_run <= last;
    end
  end

endmodule
